// ===== rtl/core/palette_crossfade_cycler_macros.svh =====
// Assertion helpers for the palette crossfade cycler.
`ifndef PALETTE_CROSSFADE_CYCLER_MACROS_SVH
`define PALETTE_CROSSFADE_CYCLER_MACROS_SVH

`ifndef SYNTHESIS

`define PCC_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

`define PCC_ASSERT(lbl, prop, msg) \
  `PCC_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`else

`define PCC_ASSERT_CLK(lbl, clk, rstn, prop, msg)

`define PCC_ASSERT(lbl, prop, msg)

`endif

`endif

// ===== rtl/core/pcc_pkg.sv =====
`default_nettype none

package pcc_pkg;

  localparam int TICK_MS       = 16;
  localparam int PALETTE_DEPTH = 8;

  localparam int IDX_W   = $clog2(PALETTE_DEPTH);
  localparam int N_W     = $clog2(PALETTE_DEPTH + 1);
  localparam int TIME_W  = 14;
  localparam int COUNT_W = 4;
  localparam int CFG_W   = 14;
  localparam int CFG_IDX_W = 2;
  localparam int SLOT_W  = 3;
  localparam int COLOR_W = 32;
  localparam int CH_W    = 8;
  localparam int Q_W     = 8;
  localparam int WGT_W   = Q_W + 1;

  localparam logic [TIME_W-1:0]  IDLE_TIME_RST  = 14'd1000;
  localparam logic [TIME_W-1:0]  TRANS_TIME_RST = 14'd1000;
  localparam logic [COUNT_W-1:0] COUNT_RST      = 4'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IDLE_TIME   = 2'd0,
    CFG_TRANS_TIME  = 2'd1,
    CFG_COLOR_COUNT = 2'd2
  } pcc_cfg_idx_e;

  typedef struct packed {
    logic       tick_upd;
    logic       wr_en;
    logic       rd_cur;
    logic       rd_nxt;
    logic       div_init;
    logic       div_step;
    logic       blend_step;
    logic [1:0] blend_sel;
    logic       out_load;
  } pcc_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/pcc_in_if.sv =====
`default_nettype none

interface pcc_in_if import pcc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               func;
  logic [SLOT_W-1:0]  entry_index;
  logic [COLOR_W-1:0] entry_color;

  modport source (output valid, output func, output entry_index, output entry_color,
                  input ready);
  modport sink (input valid, input func, input entry_index, input entry_color,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/core/pcc_out_if.sv =====
`default_nettype none

interface pcc_out_if import pcc_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red;
  logic [CH_W-1:0] green;
  logic [CH_W-1:0] blue;
  logic [CH_W-1:0] alpha;
  logic            fading;

  modport source (output valid, output red, output green, output blue, output alpha,
                  output fading, input ready);
  modport sink (input valid, input red, input green, input blue, input alpha,
                input fading, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/pcc_ctrl.sv =====
`default_nettype none

module pcc_ctrl import pcc_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  input  wire logic     in_func_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output pcc_cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_CUR,
    S_RD_NXT,
    S_DIV,
    S_BLEND,
    S_OUT
  } state_e;

  state_e     state_q;
  logic [2:0] cnt_q;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o = '0;
    case (state_q)
      S_IDLE: begin
        cmd_o.tick_upd = in_valid_i && !in_func_i;
        cmd_o.wr_en    = in_valid_i && in_func_i;
      end
      S_RD_CUR: cmd_o.rd_cur = 1'b1;
      S_RD_NXT: begin
        cmd_o.rd_nxt   = 1'b1;
        cmd_o.div_init = 1'b1;
      end
      S_DIV: cmd_o.div_step = 1'b1;
      S_BLEND: begin
        cmd_o.blend_step = 1'b1;
        cmd_o.blend_sel  = cnt_q[1:0];
      end
      S_OUT: cmd_o.out_load = out_free;
      default: cmd_o = '0;
    endcase
  end

  // drop the result once it is taken, raise it when a new one loads
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if ((state_q == S_OUT) && out_free) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      case (state_q)
        S_IDLE: begin
          if (in_valid_i && !in_func_i) state_q <= S_RD_CUR;
        end
        S_RD_CUR: state_q <= S_RD_NXT;
        S_RD_NXT: begin
          cnt_q   <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          cnt_q <= cnt_q + 3'd1;
          if (cnt_q == 3'd7) state_q <= S_BLEND;
        end
        S_BLEND: begin
          cnt_q <= cnt_q + 3'd1;
          if (cnt_q == 3'd3) state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_free) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/pcc_dpath.sv =====
`default_nettype none

module pcc_dpath import pcc_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire pcc_cmd_t             cmd_i,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  input  wire logic [SLOT_W-1:0]    entry_index_i,
  input  wire logic [COLOR_W-1:0]   entry_color_i,
  output logic [CH_W-1:0]           red_o,
  output logic [CH_W-1:0]           green_o,
  output logic [CH_W-1:0]           blue_o,
  output logic [CH_W-1:0]           alpha_o,
  output logic                      fading_o
);

  localparam int DIFF_W = TIME_W + 1;
  localparam int SUM_W  = 2 * CH_W + 1;

  // configuration
  logic [TIME_W-1:0]  idle_q, trans_q;
  logic [COUNT_W-1:0] count_q;

  // sequencing state
  logic [TIME_W-1:0] cd_q, cd_d;
  logic              fade_q, fade_d;
  logic [IDX_W-1:0]  idx_q, idx_d;

  logic [N_W-1:0]    eff_n;
  logic [IDX_W-1:0]  idx_cl, idx_cl_nxt, idx_nxt;
  logic [DIFF_W-1:0] diff;

  // palette memory
  logic [COLOR_W-1:0] mem_q [PALETTE_DEPTH];
  logic [COLOR_W-1:0] rd_q;
  logic [COLOR_W-1:0] cur_q;
  logic [IDX_W-1:0]   rd_addr;
  logic               slot_ok;

  // divider
  logic [DIFF_W-1:0] rem_q, rem2;
  logic [Q_W-1:0]    quo_q;
  logic              sat_q, zero_q;
  logic [WGT_W-1:0]  wgt, wgt_inv;

  // blend
  logic [CH_W-1:0]  ch_a, ch_b;
  logic [SUM_W-1:0] mix;
  logic [CH_W-1:0]  res_q [4];

  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] i,
                                                input logic [N_W-1:0] n);
    logic [N_W-1:0] i1;
    i1 = N_W'(i) + N_W'(1);
    return (i1 == n) ? '0 : IDX_W'(i1);
  endfunction

  always_comb begin
    if (count_q == '0)
      eff_n = N_W'(1);
    else if (32'(count_q) > PALETTE_DEPTH)
      eff_n = N_W'(PALETTE_DEPTH);
    else
      eff_n = N_W'(count_q);
  end

  assign idx_cl     = (N_W'(idx_q) >= eff_n) ? '0 : idx_q;
  assign idx_cl_nxt = wrap_inc(idx_cl, eff_n);
  assign idx_nxt    = wrap_inc(idx_q, eff_n);
  assign diff       = {1'b0, cd_q} - DIFF_W'(TICK_MS);

  always_comb begin
    cd_d   = diff[TIME_W-1:0];
    fade_d = fade_q;
    idx_d  = idx_cl;
    if (diff[DIFF_W-1]) begin
      if (fade_q) begin
        fade_d = 1'b0;
        idx_d  = idx_cl_nxt;
        cd_d   = idle_q;
      end else begin
        fade_d = 1'b1;
        cd_d   = trans_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_q  <= IDLE_TIME_RST;
      trans_q <= TRANS_TIME_RST;
      count_q <= COUNT_RST;
      cd_q    <= '0;
      fade_q  <= 1'b0;
      idx_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        case (pcc_cfg_idx_e'(cfg_idx_i))
          CFG_IDLE_TIME:   idle_q  <= cfg_data_i[TIME_W-1:0];
          CFG_TRANS_TIME:  trans_q <= cfg_data_i[TIME_W-1:0];
          CFG_COLOR_COUNT: count_q <= cfg_data_i[COUNT_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.tick_upd) begin
        cd_q   <= cd_d;
        fade_q <= fade_d;
        idx_q  <= idx_d;
      end
    end
  end

  assign slot_ok = (32'(entry_index_i) < PALETTE_DEPTH);
  assign rd_addr = cmd_i.rd_nxt ? idx_nxt : idx_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en && slot_ok) mem_q[IDX_W'(entry_index_i)] <= entry_color_i;
    if (cmd_i.rd_cur || cmd_i.rd_nxt) rd_q <= mem_q[rd_addr];
  end

  // restoring divide: w = cd * 256 / T for cd below T
  assign rem2 = {rem_q[DIFF_W-2:0], 1'b0};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      cur_q  <= rd_q;
      rem_q  <= {1'b0, cd_q};
      quo_q  <= '0;
      sat_q  <= (cd_q >= trans_q);
      zero_q <= (trans_q == '0);
    end else if (cmd_i.div_step) begin
      if (rem2 >= {1'b0, trans_q}) begin
        rem_q <= rem2 - {1'b0, trans_q};
        quo_q <= {quo_q[Q_W-2:0], 1'b1};
      end else begin
        rem_q <= rem2;
        quo_q <= {quo_q[Q_W-2:0], 1'b0};
      end
    end
  end

  // full weight on the current color when not fading
  always_comb begin
    if (!fade_q || (sat_q && !zero_q))
      wgt = WGT_W'(256);
    else if (zero_q)
      wgt = '0;
    else
      wgt = {1'b0, quo_q};
  end

  assign wgt_inv = WGT_W'(256) - wgt;

  always_comb begin
    case (cmd_i.blend_sel)
      2'd0: begin ch_a = cur_q[31:24]; ch_b = rd_q[31:24]; end
      2'd1: begin ch_a = cur_q[23:16]; ch_b = rd_q[23:16]; end
      2'd2: begin ch_a = cur_q[15:8];  ch_b = rd_q[15:8];  end
      default: begin ch_a = cur_q[7:0]; ch_b = rd_q[7:0]; end
    endcase
  end

  assign mix = SUM_W'(ch_a) * SUM_W'(wgt) + SUM_W'(ch_b) * SUM_W'(wgt_inv);

  always_ff @(posedge clk_i) begin
    if (cmd_i.blend_step) res_q[cmd_i.blend_sel] <= mix[2*CH_W-1:CH_W];
    if (cmd_i.out_load) begin
      red_o    <= res_q[0];
      green_o  <= res_q[1];
      blue_o   <= res_q[2];
      alpha_o  <= res_q[3];
      fading_o <= fade_q;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/palette_crossfade_cycler.sv =====
// Tick beat: after acceptance come two palette reads, an 8-step
// restoring divide, 4 per-channel blend steps and the output load, which
// waits while an earlier result is unread. A new tick is taken only once
// the last one has loaded its result; a palette write beat gives no result.
// Reset (async, active low): timing registers to 1000 ms, count to 1,
// countdown, fade flag and index cleared; palette contents are not cleared.
`default_nettype none

`include "palette_crossfade_cycler_macros.svh"

module palette_crossfade_cycler import pcc_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  pcc_in_if.sink                    in_i,
  pcc_out_if.source                 out_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i
);

  pcc_cmd_t cmd;
  logic     in_ready;
  logic     out_valid;

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;

  pcc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_func_i   (in_i.func),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd)
  );

  pcc_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .entry_index_i (in_i.entry_index),
    .entry_color_i (in_i.entry_color),
    .red_o         (out_o.red),
    .green_o       (out_o.green),
    .blue_o        (out_o.blue),
    .alpha_o       (out_o.alpha),
    .fading_o      (out_o.fading)
  );

  `PCC_ASSERT(a_tick_busy, in_i.valid && in_ready && !in_i.func |=> !in_ready, "tick not held")
  `PCC_ASSERT(a_write_single, in_i.valid && in_ready && in_i.func |=> in_ready, "write stalled")
  `PCC_ASSERT(a_load_cmd, cmd.out_load |=> out_valid, "loaded result not presented")

endmodule

`default_nettype wire
